### hw/rtl/hpcd_pkg.sv
// ----------------------------------------------------------------------------
// hpcd_pkg
// Shared types and constants of the hi-hat pedal chick detector.
// ----------------------------------------------------------------------------
package hpcd_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned TMS_W    = 23;  // time_us / 1000 fits in 23 bits
  localparam int unsigned VEL_W    = 7;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned TOUT_W   = 16;
  localparam int unsigned PROD_W   = 23;  // 16-bit magnitude times 126

  // Stream payload widths (whole bytes)
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 24;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Sensor full scale
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 12'd4095;

  // Microseconds to milliseconds: (t * ceil(2^38 / 1000)) >> 38, exact for 32 bits
  localparam int unsigned           MS_RECIP_W = 29;
  localparam logic [MS_RECIP_W-1:0] MS_RECIP   = 29'd274877907;
  localparam int unsigned           MS_SHIFT   = 38;

  // Velocity divider setup: quotient bits and scale
  localparam logic [4:0]        VDIV_STEPS = 5'd7;
  localparam logic [VEL_W:0]    VEL_SCALE  = 8'd126;

  // Register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_ENABLE     = 3'd0,
    CFG_ZONE_MIN   = 3'd1,
    CFG_ZONE_MAX   = 3'd2,
    CFG_CLOSED_TH  = 3'd3,
    CFG_ALMOST_TH  = 3'd4,
    CFG_TIMEOUT    = 3'd5,
    CFG_MOVE_TOL   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic                enable;
    logic [11:0]         zone_min;
    logic [11:0]         zone_max;
    logic [6:0]          closed_th;
    logic [6:0]          almost_th;
    logic [TOUT_W-1:0]   timeout;
    logic [7:0]          move_tol;
  } cfg_t;

  // Pedal machine codes
  typedef enum logic [MODE_W-1:0] {
    MODE_OPEN   = 2'd0,
    MODE_ALMOST = 2'd1,
    MODE_CLOSED = 2'd2
  } mode_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TDIV,
    ST_EVAL,
    ST_VSUB,
    ST_VMUL,
    ST_VCHK,
    ST_VDIV,
    ST_OUT
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;        // take the item, filter sample, scale time to ms
    logic eval;        // classify pedal, step the machine
    logic vsub;        // time difference against timeout
    logic vmul;        // magnitude times 126
    logic vneg;        // velocity for a late close
    logic vdiv_start;  // start velocity divide
    logic vdiv_done;   // take velocity from quotient
    logic out_load;    // load output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_busy;
    logic chick;
    logic neg;
    logic out_free;
  } dp_sts_t;

endpackage

### hw/rtl/hihat_pedal_chick_detector.sv
// ----------------------------------------------------------------------------
// hihat_pedal_chick_detector
// Hi-hat pedal position tracker with chick hit detection.
// ----------------------------------------------------------------------------
// Input stream s_axis carries one pedal sample with its microsecond time.
// Output stream m_axis carries the filtered value, hit flag, velocity and
// pedal state for each item taken while the pad is enabled; with enable
// low, items are taken and dropped without a result.
// Registers are written through cfg_we_i/cfg_addr_i/cfg_wdata_i; the user
// must write them only while idle, which the block itself does not enforce.
// An item is handled one at a time. The timestamp is scaled to milliseconds
// by a reciprocal multiply as the item is taken; the zone products are
// registered in ST_TDIV and the zone compare follows in ST_EVAL, after
// which an item without a chick goes to ST_OUT. A chick adds the velocity
// path: setup states ST_VSUB, ST_VMUL and ST_VCHK, then a 7-step divide
// with the quotient taken in ST_VDIV when the close is within the timeout,
// or the late-close velocity set in ST_VCHK. s_axis_tready is high again
// once the result sits in the output register, so the next item is taken
// while a result still waits. If the receiver stalls with a result pending,
// the next finished item waits in the sequencer until the output register
// frees up.
// Reset restores the default registers, an open pedal and a zero filter.
// ----------------------------------------------------------------------------
module hihat_pedal_chick_detector (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // raw_sample [11:0], time_us [43:12], zero [47:44]
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [hpcd_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // denoised_value [11:0], hit [12], hit_velocity [19:13],
  // pedal_state [21:20], zero [23:22]
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [hpcd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [hpcd_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [hpcd_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import hpcd_pkg::*;

  cfg_t                cfg;
  dp_cmd_t             cmd;
  dp_sts_t             sts;
  logic [SAMPLE_W-1:0] out_value;
  logic                out_hit;
  logic [VEL_W-1:0]    out_vel;
  logic [MODE_W-1:0]   out_mode;

  hpcd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .addr_i  (cfg_addr_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  hpcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .enable_i   (cfg.enable),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hpcd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .sample_i    (s_axis_tdata[SAMPLE_W-1:0]),
    .time_i      (s_axis_tdata[SAMPLE_W+TIME_W-1:SAMPLE_W]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_value_o (out_value),
    .out_hit_o   (out_hit),
    .out_vel_o   (out_vel),
    .out_mode_o  (out_mode)
  );

  assign m_axis_tdata = {2'b00, out_mode, out_vel, out_hit, out_value};

endmodule

### hw/rtl/hpcd_cfg.sv
// ----------------------------------------------------------------------------
// hpcd_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module hpcd_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            we_i,
  input  logic [hpcd_pkg::CFG_ADDR_W-1:0] addr_i,
  input  logic [hpcd_pkg::CFG_DATA_W-1:0] wdata_i,
  output hpcd_pkg::cfg_t                  cfg_o
);
  import hpcd_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (cfg_idx_e'(addr_i))
        CFG_ENABLE:    cfg_d.enable    = wdata_i[0];
        CFG_ZONE_MIN:  cfg_d.zone_min  = wdata_i[11:0];
        CFG_ZONE_MAX:  cfg_d.zone_max  = wdata_i[11:0];
        CFG_CLOSED_TH: cfg_d.closed_th = wdata_i[6:0];
        CFG_ALMOST_TH: cfg_d.almost_th = wdata_i[6:0];
        CFG_TIMEOUT:   cfg_d.timeout   = wdata_i[TOUT_W-1:0];
        CFG_MOVE_TOL:  cfg_d.move_tol  = wdata_i[7:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable    <= 1'b0;
      cfg_q.zone_min  <= 12'd0;
      cfg_q.zone_max  <= 12'd4095;
      cfg_q.closed_th <= 7'd90;
      cfg_q.almost_th <= 7'd70;
      cfg_q.timeout   <= 16'd100;
      cfg_q.move_tol  <= 8'd4;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hw/rtl/hpcd_div.sv
// ----------------------------------------------------------------------------
// hpcd_div
// Restoring divider, one quotient bit per cycle, with a pre-shifted divisor.
// ----------------------------------------------------------------------------
module hpcd_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [hpcd_pkg::TIME_W-1:0]   dividend_i,
  input  logic [hpcd_pkg::TIME_W-1:0]   dsh_i,
  input  logic [4:0]                    steps_i,
  output logic                          busy_o,
  output logic [hpcd_pkg::TMS_W-1:0]    quo_o
);
  import hpcd_pkg::*;

  logic [TIME_W-1:0] rem_q, rem_d;
  logic [TIME_W-1:0] dsh_q, dsh_d;
  logic [TMS_W-1:0]  quo_q, quo_d;
  logic [4:0]        cnt_q, cnt_d;
  logic              ge;

  // One compare and subtract per step
  always_comb begin
    ge    = rem_q >= dsh_q;
    rem_d = rem_q;
    dsh_d = dsh_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    if (start_i) begin
      rem_d = dividend_i;
      dsh_d = dsh_i;
      quo_d = '0;
      cnt_d = steps_i;
    end else if (cnt_q != 5'd0) begin
      if (ge) begin
        rem_d = rem_q - dsh_q;
      end
      quo_d = {quo_q[TMS_W-2:0], ge};
      dsh_d = dsh_q >> 1;
      cnt_d = cnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 5'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
  end

  assign busy_o = cnt_q != 5'd0;
  assign quo_o  = quo_q;

endmodule

### hw/rtl/hpcd_ctrl.sv
// ----------------------------------------------------------------------------
// hpcd_ctrl
// Sequencer: steps one item through filter, time scaling, pedal machine,
// velocity path and output register.
// ----------------------------------------------------------------------------
module hpcd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              enable_i,
  input  hpcd_pkg::dp_sts_t sts_i,
  output hpcd_pkg::dp_cmd_t cmd_o
);
  import hpcd_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        // a disabled pad drops the item
        if (in_valid_i && enable_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_TDIV;
        end
      end
      ST_TDIV: begin
        // zone products pick up the new filter value
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.chick ? ST_VSUB : ST_OUT;
      end
      ST_VSUB: begin
        cmd_o.vsub = 1'b1;
        state_d    = ST_VMUL;
      end
      ST_VMUL: begin
        cmd_o.vmul = 1'b1;
        state_d    = ST_VCHK;
      end
      ST_VCHK: begin
        if (sts_i.neg) begin
          cmd_o.vneg = 1'b1;
          state_d    = ST_OUT;
        end else begin
          cmd_o.vdiv_start = 1'b1;
          state_d          = ST_VDIV;
        end
      end
      ST_VDIV: begin
        if (!sts_i.div_busy) begin
          cmd_o.vdiv_done = 1'b1;
          state_d         = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

### hw/rtl/hpcd_dp.sv
// ----------------------------------------------------------------------------
// hpcd_dp
// Datapath: deadband filter, zone products, pedal machine state, velocity
// arithmetic on a serial divider, and the output register.
// ----------------------------------------------------------------------------
module hpcd_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  hpcd_pkg::cfg_t                   cfg_i,
  input  hpcd_pkg::dp_cmd_t                cmd_i,
  output hpcd_pkg::dp_sts_t                sts_o,
  input  logic [hpcd_pkg::SAMPLE_W-1:0]    sample_i,
  input  logic [hpcd_pkg::TIME_W-1:0]      time_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [hpcd_pkg::SAMPLE_W-1:0]    out_value_o,
  output logic                             out_hit_o,
  output logic [hpcd_pkg::VEL_W-1:0]       out_vel_o,
  output logic [hpcd_pkg::MODE_W-1:0]      out_mode_o
);
  import hpcd_pkg::*;

  // Pedal state
  logic [SAMPLE_W-1:0] filt_q, filt_d;
  mode_e               mode_q, mode_d;
  logic [TMS_W-1:0]    acts_q, acts_d;

  // Item time in milliseconds
  logic [TIME_W+MS_RECIP_W-1:0] tms_prod;
  logic [TMS_W-1:0]             tms_q;

  // Zone products
  logic signed [19:0]  lhs_q;
  logic [18:0]         rc_q, ra_q;
  logic                empty_q;

  // Velocity path
  logic [TIME_W-1:0]   t_q;
  logic [TOUT_W-1:0]   mag_q;
  logic                neg_q, big_q;
  logic [PROD_W-1:0]   prod_q;
  logic [VEL_W-1:0]    vel_q;

  // Output register
  logic                ov_q;
  logic [SAMPLE_W-1:0] ov_value_q;
  logic                ov_hit_q;
  logic [VEL_W-1:0]    ov_vel_q;
  logic [MODE_W-1:0]   ov_mode_q;

  // Divider
  logic                div_start;
  logic [TIME_W-1:0]   div_dividend, div_dsh;
  logic [4:0]          div_steps;
  logic                div_busy;
  logic [TMS_W-1:0]    div_quo;

  logic [TOUT_W-1:0]   teff;
  logic [SAMPLE_W-1:0] diff;
  logic                closed, almost, open_p, chick;
  logic [TIME_W-1:0]   nn;
  mode_e               m1;
  logic [TMS_W-1:0]    acts1;

  assign teff = (cfg_i.timeout == '0) ? 16'd1 : cfg_i.timeout;

  // Deadband filter
  always_comb begin
    diff   = (sample_i > filt_q) ? sample_i - filt_q : filt_q - sample_i;
    filt_d = filt_q;
    if (cmd_i.load && sample_i != filt_q &&
        (diff >= {4'd0, cfg_i.move_tol} || sample_i == '0 || sample_i >= SAMPLE_MAX)) begin
      filt_d = (sample_i < SAMPLE_MAX) ? sample_i : SAMPLE_MAX;
    end
  end

  // Timestamp to milliseconds by reciprocal multiply, taken with the item
  assign tms_prod = {{MS_RECIP_W{1'b0}}, time_i} * {{TIME_W{1'b0}}, MS_RECIP};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tms_q <= tms_prod[MS_SHIFT+TMS_W-1:MS_SHIFT];
    end
  end

  // Zone products, refreshed every cycle
  always_ff @(posedge clk_i) begin
    lhs_q   <= 20'($signed({1'b0, filt_q}) - $signed({1'b0, cfg_i.zone_min}))
               * 20'sd100;
    rc_q    <= 19'(cfg_i.closed_th * (cfg_i.zone_max - cfg_i.zone_min));
    ra_q    <= 19'(cfg_i.almost_th * (cfg_i.zone_max - cfg_i.zone_min));
    empty_q <= cfg_i.zone_max <= cfg_i.zone_min;
  end

  // Pedal classification and machine
  always_comb begin
    closed = !empty_q && (lhs_q >= $signed({1'b0, rc_q}));
    almost = !closed && !empty_q && (lhs_q >= $signed({1'b0, ra_q}));
    open_p = !closed && !almost;
    m1     = mode_q;
    acts1  = acts_q;
    if (!open_p && mode_q == MODE_OPEN) begin
      acts1 = tms_q;
      m1    = MODE_ALMOST;
    end
    chick  = closed && m1 == MODE_ALMOST;
    mode_d = m1;
    if (chick) begin
      mode_d = MODE_CLOSED;
    end else if ((!closed && m1 == MODE_CLOSED) || (open_p && m1 == MODE_ALMOST)) begin
      mode_d = MODE_OPEN;
    end
    acts_d = acts1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q <= '0;
      mode_q <= MODE_OPEN;
      acts_q <= '0;
    end else begin
      filt_q <= filt_d;
      if (cmd_i.eval) begin
        mode_q <= mode_d;
        acts_q <= acts_d;
      end
    end
  end

  // Velocity arithmetic
  assign nn = t_q - {16'd0, teff};

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      t_q   <= {9'd0, tms_q} - {9'd0, acts1};
      vel_q <= '0;
    end
    if (cmd_i.vsub) begin
      neg_q <= t_q > {16'd0, teff};
      big_q <= nn[31:16] != 16'd0;
      mag_q <= (t_q > {16'd0, teff}) ? nn[15:0] : teff - t_q[15:0];
    end
    if (cmd_i.vmul) begin
      prod_q <= PROD_W'({7'd0, mag_q} * {15'd0, VEL_SCALE});
    end
    if (cmd_i.vneg) begin
      // closed later than the timeout: only a tiny overrun still scores one
      vel_q <= (!big_q && prod_q < {7'd0, teff}) ? 7'd1 : 7'd0;
    end
    if (cmd_i.vdiv_done) begin
      vel_q <= div_quo[VEL_W-1:0] + 7'd1;
    end
  end

  // Divider operands: scaled magnitude over the pre-shifted timeout
  assign div_start    = cmd_i.vdiv_start;
  assign div_dividend = {9'd0, prod_q};
  assign div_dsh      = {10'd0, teff, 6'd0};
  assign div_steps    = VDIV_STEPS;

  hpcd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .dsh_i      (div_dsh),
    .steps_i    (div_steps),
    .busy_o     (div_busy),
    .quo_o      (div_quo)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      ov_value_q <= filt_q;
      ov_hit_q   <= vel_q != '0;
      ov_vel_q   <= vel_q;
      ov_mode_q  <= mode_q;
    end
  end

  assign out_valid_o = ov_q;
  assign out_value_o = ov_value_q;
  assign out_hit_o   = ov_hit_q;
  assign out_vel_o   = ov_vel_q;
  assign out_mode_o  = ov_mode_q;

  // Status
  assign sts_o.div_busy = div_busy;
  assign sts_o.chick    = chick;
  assign sts_o.neg      = neg_q;
  assign sts_o.out_free = !ov_q || out_ready_i;

endmodule

### sim/hihat_pedal_chick_detector_test.sv
// ----------------------------------------------------------------------------
// hihat_pedal_chick_detector_test
// Self-checking bench for the hi-hat pedal chick detector.
// ----------------------------------------------------------------------------
// Pedal samples with microsecond stamps are streamed into the block. On each
// item taken while enabled a behavioral tracker finds the filtered value, pedal
// state and chick velocity, and the result is checked field by field against
// the output stream. A short directed run covers the filter edges, every
// state step, late, instant and wrapped closes, and odd register settings.
// Random pedal strokes under changing settings and handshake pressure follow.
// ----------------------------------------------------------------------------
module hihat_pedal_chick_detector_test;

  import hpcd_pkg::*;

  localparam int SETTLE_CYCLES = 60;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int LONG_HOLD     = 400;

  // One pedal sample as it goes on the input stream
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [TIME_W-1:0]   t_us;
  } pedal_item_t;

  // One result as it comes from the output stream
  typedef struct packed {
    logic [SAMPLE_W-1:0] level;
    logic                hit;
    logic [VEL_W-1:0]    vel;
    logic [MODE_W-1:0]   mode;
  } pedal_report_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;

  // Tracker copy of registers and pedal state
  cfg_t                  cfg_model;
  logic [SAMPLE_W-1:0]   filt_q;
  mode_e                 mode_q;
  logic [TIME_W-1:0]     almost_ms_q;

  pedal_item_t           pending_q[$];
  pedal_report_t         pedal_reports_due[$];

  int unsigned           offered_cnt;
  int unsigned           taken_cnt;
  int unsigned           result_cnt;
  int unsigned           made_cnt;
  int unsigned           mismatch_cnt;
  int unsigned           cycle_cnt;
  int unsigned           send_idle_pct;
  int unsigned           recv_idle_pct;
  int unsigned           stall_asks;
  int unsigned           stall_seen;
  int unsigned           stall_left;
  logic [TIME_W-1:0]     clock_us;

  hihat_pedal_chick_detector i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Tracker
  // --------------------------------------------------------------------------

  // Exact percent test by cross-multiplication; empty zone never reaches
  function automatic bit zone_reaches(logic [SAMPLE_W-1:0] v, logic [6:0] pct);
    longint lo, hi, lv, lp;
    lo = cfg_model.zone_min;
    hi = cfg_model.zone_max;
    lv = v;
    lp = pct;
    if (hi <= lo) return 1'b0;
    return (lv - lo) * 100 >= lp * (hi - lo);
  endfunction

  function automatic pedal_report_t track_pedal(logic [SAMPLE_W-1:0] sample,
                                                logic [TIME_W-1:0] t_us);
    pedal_report_t     r;
    logic [SAMPLE_W-1:0] diff;
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] span_ms;
    longint            tmo, span, v;
    bit                closed, almost, open_p;
    now_ms = t_us / 1000;
    r = '0;
    // deadband: zero and full scale always get through
    diff = (sample > filt_q) ? sample - filt_q : filt_q - sample;
    if (sample != filt_q &&
        (diff >= cfg_model.move_tol || sample == 0 || sample >= SAMPLE_MAX)) begin
      filt_q = sample;
    end
    closed = zone_reaches(filt_q, cfg_model.closed_th);
    almost = !closed && zone_reaches(filt_q, cfg_model.almost_th);
    open_p = !closed && !almost;
    if (!open_p && mode_q == MODE_OPEN) begin
      almost_ms_q = now_ms;
      mode_q = MODE_ALMOST;
    end
    // chick on the almost -> closed step; wrapped span gives a late close
    if (closed && mode_q == MODE_ALMOST) begin
      span_ms = now_ms - almost_ms_q;
      span = span_ms;
      tmo = (cfg_model.timeout == 0) ? 1 : cfg_model.timeout;
      v = ((tmo - span) * 126) / tmo + 1;
      if (v < 0) v = 0;
      r.vel = v[VEL_W-1:0];
      r.hit = (v > 0);
      mode_q = MODE_CLOSED;
    end
    if ((!closed && mode_q == MODE_CLOSED) || (open_p && mode_q == MODE_ALMOST)) begin
      mode_q = MODE_OPEN;
    end
    r.level = filt_q;
    r.mode = mode_q;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stream side processes
  // --------------------------------------------------------------------------

  // Sender: one item on the bus until taken, random gaps between items
  always @(negedge clk_i) begin : drive_items
    pedal_item_t it;
    if (s_axis_tvalid && taken_cnt != offered_cnt) begin
      // hold the current item
    end else if (rst_ni && pending_q.size() != 0 &&
                 $urandom_range(0, 99) >= send_idle_pct) begin
      it = pending_q.pop_front();
      s_axis_tdata <= {4'b0, it.t_us, it.sample};
      s_axis_tvalid <= 1'b1;
      offered_cnt++;
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // Receiver: random stalls plus an occasional long hold-off
  always @(negedge clk_i) begin
    if (stall_seen != stall_asks) begin
      stall_seen = stall_asks;
      stall_left = LONG_HOLD;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic report_mismatch(string msg);
    mismatch_cnt++;
    $display("mismatch: %s", msg);
  endtask

  // Result check first, then the tracker for a newly taken item
  always @(posedge clk_i) begin : watch_results
    pedal_report_t got, want;
    string         msg;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.level = m_axis_tdata[11:0];
        got.hit   = m_axis_tdata[12];
        got.vel   = m_axis_tdata[19:13];
        got.mode  = m_axis_tdata[21:20];
        result_cnt++;
        if (pedal_reports_due.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing due", result_cnt));
        end else begin
          want = pedal_reports_due.pop_front();
          msg = "";
          if (got.level != want.level)
            msg = {msg, $sformatf(" level %0d want %0d", got.level, want.level)};
          if (got.hit != want.hit)
            msg = {msg, $sformatf(" hit %0d want %0d", got.hit, want.hit)};
          if (got.vel != want.vel)
            msg = {msg, $sformatf(" vel %0d want %0d", got.vel, want.vel)};
          if (got.mode != want.mode)
            msg = {msg, $sformatf(" mode %0d want %0d", got.mode, want.mode)};
          if (msg != "") report_mismatch($sformatf("result %0d:%s", result_cnt, msg));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (cfg_model.enable) begin
          pedal_reports_due.push_back(track_pedal(s_axis_tdata[11:0], s_axis_tdata[43:12]));
        end
        taken_cnt++;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_ENABLE:    cfg_model.enable    = val[0];
      CFG_ZONE_MIN:  cfg_model.zone_min  = val[11:0];
      CFG_ZONE_MAX:  cfg_model.zone_max  = val[11:0];
      CFG_CLOSED_TH: cfg_model.closed_th = val[6:0];
      CFG_ALMOST_TH: cfg_model.almost_th = val[6:0];
      CFG_TIMEOUT:   cfg_model.timeout   = val;
      CFG_MOVE_TOL:  cfg_model.move_tol  = val[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_setup(logic en, logic [11:0] zmin, logic [11:0] zmax,
                            logic [6:0] cth, logic [6:0] ath,
                            logic [15:0] tmo, logic [7:0] tol);
    write_reg(CFG_ENABLE, 16'(en));
    write_reg(CFG_ZONE_MIN, 16'(zmin));
    write_reg(CFG_ZONE_MAX, 16'(zmax));
    write_reg(CFG_CLOSED_TH, 16'(cth));
    write_reg(CFG_ALMOST_TH, 16'(ath));
    write_reg(CFG_TIMEOUT, tmo);
    write_reg(CFG_MOVE_TOL, 16'(tol));
  endtask

  task automatic shuffle_setup();
    int unsigned zmin, zmax, cth, ath;
    zmin = $urandom_range(0, 1500);
    zmax = $urandom_range(zmin + 300, 4095);
    cth = $urandom_range(50, 100);
    ath = $urandom_range(10, cth);
    load_setup(1'b1, 12'(zmin), 12'(zmax), 7'(cth), 7'(ath),
               16'($urandom_range(1, 400)), 8'($urandom_range(0, 30)));
  endtask

  // Wait until every item is taken and every result is in, then let the
  // block run out its latency (disabled items leave no result behind)
  task automatic settle();
    do @(negedge clk_i);
    while (pending_q.size() != 0 || taken_cnt != offered_cnt ||
           pedal_reports_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic queue_item(logic [SAMPLE_W-1:0] sample, logic [TIME_W-1:0] t_us);
    pedal_item_t it;
    it.sample = sample;
    it.t_us = t_us;
    pending_q.push_back(it);
    made_cnt++;
  endtask

  // Sample at a percent of the current zone, with a little jitter
  function automatic logic [SAMPLE_W-1:0] zone_point(int unsigned pct);
    int lo, hi, s;
    lo = cfg_model.zone_min;
    hi = cfg_model.zone_max;
    if (hi <= lo) return 12'($urandom_range(0, 4095));
    s = lo + ((hi - lo) * int'(pct)) / 100 + int'($urandom_range(0, 6)) - 3;
    if (s < 0) s = 0;
    if (s > 4095) s = 4095;
    return 12'(s);
  endfunction

  // Full pedal stroke: open, an optional almost band, close early or late, release
  task automatic press_stroke();
    int unsigned tmo, ath, cth, steps;
    tmo = (cfg_model.timeout == 0) ? 1 : cfg_model.timeout;
    ath = cfg_model.almost_th;
    cth = cfg_model.closed_th;
    steps = $urandom_range(1, 3);
    repeat (steps) begin
      clock_us += $urandom_range(200, 20000);
      queue_item(zone_point($urandom_range(0, ath / 2)), clock_us);
    end
    // sometimes jump straight from open to closed
    if ($urandom_range(0, 4) != 0) begin
      steps = $urandom_range(1, 2);
      repeat (steps) begin
        clock_us += $urandom_range(0, 5000);
        queue_item(zone_point(ath + ((cth > ath) ? $urandom_range(0, cth - ath - 1) : 0)),
                   clock_us);
      end
    end
    clock_us += $urandom_range(0, tmo * 1300);
    queue_item(zone_point(cth + $urandom_range(0, 8)), clock_us);
    steps = $urandom_range(0, 2);
    repeat (steps) begin
      clock_us += $urandom_range(500, 10000);
      queue_item(zone_point(cth + $urandom_range(0, 20)), clock_us);
    end
    // release, fully or only back into the almost band
    steps = $urandom_range(1, 2);
    repeat (steps) begin
      clock_us += $urandom_range(500, 30000);
      queue_item(zone_point($urandom_range(0, ath)), clock_us);
    end
  endtask

  // Hover near the almost or closed threshold with small moves, then drop open
  task automatic hover_stroke();
    int unsigned base, steps, tol;
    base = ($urandom_range(0, 1) != 0) ? cfg_model.almost_th : cfg_model.closed_th;
    tol = cfg_model.move_tol;
    steps = $urandom_range(2, 5);
    repeat (steps) begin
      clock_us += $urandom_range(100, 3000);
      queue_item(zone_point(base) + 12'($urandom_range(0, tol + 2)), clock_us);
    end
    clock_us += $urandom_range(100, 3000);
    queue_item(zone_point(0), clock_us);
  endtask

  task automatic noise_item();
    if ($urandom_range(0, 3) == 0) clock_us = $urandom;
    queue_item(12'($urandom), $urandom);
  endtask

  task automatic random_phase(int unsigned n);
    int unsigned start, pick;
    start = made_cnt;
    clock_us = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3000000)
                                           : $urandom;
    while (made_cnt - start < n) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) press_stroke();
      else if (pick < 9) noise_item();
      else hover_stroke();
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    cfg_model.enable = 1'b0;
    cfg_model.zone_min = 12'd0;
    cfg_model.zone_max = 12'd4095;
    cfg_model.closed_th = 7'd90;
    cfg_model.almost_th = 7'd70;
    cfg_model.timeout = 16'd100;
    cfg_model.move_tol = 8'd4;
    filt_q = '0;
    mode_q = MODE_OPEN;
    almost_ms_q = '0;
    send_idle_pct = 26;
    recv_idle_pct = 67;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // disabled after reset: taken and dropped
    queue_item(12'd4095, 32'd0);
    queue_item(12'd3000, 32'd1000);
    queue_item(12'd0, 32'd2000);
    settle();

    // directed: filter edges and every machine step at default settings
    load_setup(1'b1, 12'd0, 12'd4095, 7'd90, 7'd70, 16'd100, 8'd4);
    queue_item(12'd0, 32'd0);                 // same as filter
    queue_item(12'd2, 32'd1000);              // under tolerance
    queue_item(12'd4, 32'd2000);              // exactly tolerance
    queue_item(12'd1, 32'd3000);              // under tolerance again
    queue_item(12'd0, 32'd4000);              // zero always passes
    queue_item(12'd4095, 32'd4999);           // open to closed at once
    queue_item(12'd3000, 32'd6000);           // closed back to open
    queue_item(12'd3000, 32'd7000);           // enter almost
    queue_item(12'd3800, 32'd57000);          // chick mid timeout
    queue_item(12'd100, 32'd60000);
    queue_item(12'd3000, 32'd100000);
    queue_item(12'd4000, 32'd400000);         // late close, no hit
    queue_item(12'd2000, 32'd401000);
    queue_item(12'd3000, 32'd4294967000);     // almost at top of time
    queue_item(12'd4095, 32'd500);            // close after time wrap
    queue_item(12'd4095, 32'hFFFF_FFFF);
    queue_item(12'd3500, 32'd2000);
    queue_item(12'd2500, 32'd3000);
    queue_item(12'd3400, 32'd4000);
    queue_item(12'd3300, 32'd5000);
    queue_item(12'd500, 32'd6000);            // almost back to open
    settle();
    // empty zone
    load_setup(1'b1, 12'd2000, 12'd2000, 7'd90, 7'd70, 16'd0, 8'd0);
    queue_item(12'd4095, 32'd8000);
    settle();
    // thresholds at and above 100
    load_setup(1'b1, 12'd0, 12'd4095, 7'd127, 7'd100, 16'd0, 8'd0);
    queue_item(12'd4095, 32'd9000);
    settle();
    // zero timeout
    load_setup(1'b1, 12'd0, 12'd4095, 7'd90, 7'd70, 16'd0, 8'd0);
    queue_item(12'd3000, 32'd10000);
    queue_item(12'd4095, 32'd11000);
    settle();

    // random strokes, sender lightly idle, receiver mostly stalled
    load_setup(1'b1, 12'd0, 12'd4095, 7'd90, 7'd70, 16'd100, 8'd4);
    random_phase(240);
    settle();
    shuffle_setup();
    write_reg(CFG_MOVE_TOL, 16'd0);
    random_phase(240);
    settle();
    load_setup(1'b1, 12'd0, 12'd4095, 7'd100, 7'd0, 16'd1, 8'd255);
    random_phase(200);
    settle();

    // roles swapped; long receiver hold while items keep coming
    send_idle_pct = 67;
    recv_idle_pct = 26;
    shuffle_setup();
    write_reg(CFG_TIMEOUT, 16'hFFFF);
    stall_asks++;
    random_phase(240);
    settle();
    shuffle_setup();
    write_reg(CFG_CLOSED_TH, 16'd127);
    write_reg(CFG_ALMOST_TH, 16'd127);
    random_phase(60);
    settle();
    write_reg(CFG_ZONE_MIN, 16'd4095);
    write_reg(CFG_ZONE_MAX, 16'd0);
    random_phase(30);
    settle();
    shuffle_setup();
    write_reg(CFG_CLOSED_TH, 16'd0);
    write_reg(CFG_ALMOST_TH, 16'd0);
    random_phase(40);
    settle();

    // no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    shuffle_setup();
    write_reg(CFG_TIMEOUT, 16'd0);
    random_phase(220);
    settle();
    shuffle_setup();
    random_phase(100);
    settle();
    // pad switched off for a while, then back on
    write_reg(CFG_ENABLE, 16'd0);
    repeat (30) noise_item();
    settle();
    write_reg(CFG_ENABLE, 16'd1);
    stall_asks++;
    random_phase(100);
    settle();

    if (mismatch_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
